[src/calt_pkg.sv]
// Shared constants, codes and calendar helper functions for the calendar time counter.
package calt_pkg;

  // Field widths
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned PRESC_W  = 10;

  // Action codes of an input word
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Reset values
  localparam logic [PRESC_W-1:0] TPS_RESET   = 10'd1000;
  localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;

  // Wrap limits: a counter at or above its limit rolls over with a carry
  localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
  localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
  localparam logic [YEAR_W-1:0]   YEAR_LAST   = 14'd9999;

  // Month numbers used in the length decoder
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Reciprocal of 100 scaled by 2^19; exact quotient for every 14-bit year
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // Gregorian leap rule: divisible by 4, except by 100 unless by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [26:0]       prod;
    logic [7:0]        q;
    logic [YEAR_W-1:0] back;
    prod = 27'(y) * 27'(RECIP_100);
    q    = prod[26:RECIP_SHIFT];
    back = YEAR_W'(q) * 14'd100;
    return (y[1:0] == 2'b00) && ((back != y) || (q[1:0] == 2'b00));
  endfunction

  // Days in a month; months outside 1..12 count as 31 days
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m) inside
      MON_FEB:                            d = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:          d = 5'd31;
      default:                            d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

[src/calendar_time_counter.sv]
// Top level of the calendar time counter: prescaler, date-time counters and output register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per millisecond tick
//   (action = tick) or a load of a full date and time (action = load).
//   Config channel (cfg_valid/cfg_ready) writes ticks_per_second; it is
//   always ready and should be written only while the counter is idle.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   the date-time after that word and second_pulse, set when a tick closed
//   a second.
// Output: the result is registered and valid in the cycle after the input word is accepted.
// Throughput: one word per cycle unless a result waits on out_ready; the
//   counters update in a single pass of carry logic between the state registers,
//   which also act as the output register.
// Stall: while a result waits on out_ready, in_ready is low, and it rises
//   in the same cycle the result is taken.
// Reset: synchronous; clears the prescaler, sets 2000-01-01 00:00:00,
//   ticks_per_second = 1000, and empties the output register.
module calendar_time_counter (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [13:0] new_year,
  input  logic [3:0]  new_month,
  input  logic [4:0]  new_day,
  input  logic [4:0]  new_hour,
  input  logic [5:0]  new_minute,
  input  logic [5:0]  new_second,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] cur_year,
  output logic [3:0]  cur_month,
  output logic [4:0]  cur_day,
  output logic [4:0]  cur_hour,
  output logic [5:0]  cur_minute,
  output logic [5:0]  cur_second,
  output logic        second_pulse
);

  // State registers
  logic [calt_pkg::PRESC_W-1:0]  tps;
  logic [calt_pkg::PRESC_W-1:0]  ms_count;
  logic [calt_pkg::SECOND_W-1:0] sec_count;
  logic [calt_pkg::MINUTE_W-1:0] min_count;
  logic [calt_pkg::HOUR_W-1:0]   hour_count;
  logic [calt_pkg::DAY_W-1:0]    day_count;
  logic [calt_pkg::MONTH_W-1:0]  month_count;
  logic [calt_pkg::YEAR_W-1:0]   year_count;
  logic                          pulse;
  logic                          valid;

  // Next values
  logic [calt_pkg::PRESC_W-1:0]  ms_count_next;
  logic [calt_pkg::SECOND_W-1:0] sec_count_next;
  logic [calt_pkg::MINUTE_W-1:0] min_count_next;
  logic [calt_pkg::HOUR_W-1:0]   hour_count_next;
  logic [calt_pkg::DAY_W-1:0]    day_count_next;
  logic [calt_pkg::MONTH_W-1:0]  month_count_next;
  logic [calt_pkg::YEAR_W-1:0]   year_count_next;
  logic                          pulse_next;

  logic                         in_fire;
  logic [calt_pkg::PRESC_W:0]   ms_inc;
  logic                         sec_done;
  logic                         sec_wrap, min_wrap, hour_wrap;
  logic                         day_wrap, month_wrap, year_wrap;
  logic                         leap;
  logic [calt_pkg::DAY_W-1:0]   dim;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = !valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Prescaler compare; a prescale of zero behaves like one
  assign ms_inc   = {1'b0, ms_count} + 11'd1;
  assign sec_done = ms_inc >= {1'b0, tps};

  // Rollover conditions of each counter
  assign leap       = calt_pkg::is_leap(year_count);
  assign dim        = calt_pkg::month_days(month_count, leap);
  assign sec_wrap   = sec_count >= calt_pkg::SECOND_LAST;
  assign min_wrap   = min_count >= calt_pkg::MINUTE_LAST;
  assign hour_wrap  = hour_count >= calt_pkg::HOUR_LAST;
  assign day_wrap   = day_count >= dim;
  assign month_wrap = month_count >= calt_pkg::MONTH_LAST;
  assign year_wrap  = year_count >= calt_pkg::YEAR_LAST;

  // Load or tick with carry chain
  always_comb begin
    ms_count_next    = ms_count;
    sec_count_next   = sec_count;
    min_count_next   = min_count;
    hour_count_next  = hour_count;
    day_count_next   = day_count;
    month_count_next = month_count;
    year_count_next  = year_count;
    pulse_next       = 1'b0;
    if (action == calt_pkg::ACT_LOAD) begin
      year_count_next  = new_year;
      month_count_next = new_month;
      day_count_next   = new_day;
      hour_count_next  = new_hour;
      min_count_next   = new_minute;
      sec_count_next   = new_second;
    end else if (!sec_done) begin
      ms_count_next = ms_inc[calt_pkg::PRESC_W-1:0];
    end else begin
      ms_count_next  = '0;
      pulse_next     = 1'b1;
      sec_count_next = sec_wrap ? '0 : sec_count + 6'd1;
      if (sec_wrap) begin
        min_count_next = min_wrap ? '0 : min_count + 6'd1;
        if (min_wrap) begin
          hour_count_next = hour_wrap ? '0 : hour_count + 5'd1;
          if (hour_wrap) begin
            day_count_next = day_wrap ? calt_pkg::DAY_RESET : day_count + 5'd1;
            if (day_wrap) begin
              month_count_next = month_wrap ? calt_pkg::MONTH_RESET : month_count + 4'd1;
              if (month_wrap) begin
                year_count_next = year_wrap ? '0 : year_count + 14'd1;
              end
            end
          end
        end
      end
    end
  end

  // Counters double as the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tps         <= calt_pkg::TPS_RESET;
      ms_count    <= '0;
      sec_count   <= '0;
      min_count   <= '0;
      hour_count  <= '0;
      day_count   <= calt_pkg::DAY_RESET;
      month_count <= calt_pkg::MONTH_RESET;
      year_count  <= calt_pkg::YEAR_RESET;
      pulse       <= 1'b0;
      valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tps <= cfg_data;
      end
      if (in_fire) begin
        ms_count    <= ms_count_next;
        sec_count   <= sec_count_next;
        min_count   <= min_count_next;
        hour_count  <= hour_count_next;
        day_count   <= day_count_next;
        month_count <= month_count_next;
        year_count  <= year_count_next;
        pulse       <= pulse_next;
        valid       <= 1'b1;
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  assign out_valid    = valid;
  assign cur_year     = year_count;
  assign cur_month    = month_count;
  assign cur_day      = day_count;
  assign cur_hour     = hour_count;
  assign cur_minute   = min_count;
  assign cur_second   = sec_count;
  assign second_pulse = pulse;

  // A completed second always leaves the prescaler at zero
  a_pulse_ms_zero: assert property (@(posedge clk) disable iff (rst)
    second_pulse |-> ms_count == '0)
    else $error("second pulse with nonzero prescaler count");

  // A load shows the loaded fields and no pulse
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == calt_pkg::ACT_LOAD |=>
      cur_year == $past(new_year) && cur_second == $past(new_second) && !second_pulse)
    else $error("load not reflected in result");

  // A tick that does not close a second leaves the time fields alone
  a_tick_no_carry: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == calt_pkg::ACT_TICK && !sec_done |=>
      $stable(sec_count) && $stable(day_count) && !second_pulse)
    else $error("time changed without a second boundary");

  // Every accepted word yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted word produced no result");

  // The prescaler keeps state when no word is accepted
  a_ms_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(ms_count))
    else $error("prescaler moved without an accepted word");

endmodule

[sim/calt_checker.sv]
// Checker for the calendar time counter: predicts every result word and compares it.
`timescale 1ns / 100ps

module calt_checker (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [calt_pkg::PRESC_W-1:0]  cfg_data,
  // input words
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          action,
  input  logic [calt_pkg::YEAR_W-1:0]   new_year,
  input  logic [calt_pkg::MONTH_W-1:0]  new_month,
  input  logic [calt_pkg::DAY_W-1:0]    new_day,
  input  logic [calt_pkg::HOUR_W-1:0]   new_hour,
  input  logic [calt_pkg::MINUTE_W-1:0] new_minute,
  input  logic [calt_pkg::SECOND_W-1:0] new_second,
  // result words
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [calt_pkg::YEAR_W-1:0]   cur_year,
  input  logic [calt_pkg::MONTH_W-1:0]  cur_month,
  input  logic [calt_pkg::DAY_W-1:0]    cur_day,
  input  logic [calt_pkg::HOUR_W-1:0]   cur_hour,
  input  logic [calt_pkg::MINUTE_W-1:0] cur_minute,
  input  logic [calt_pkg::SECOND_W-1:0] cur_second,
  input  logic                          second_pulse,
  // status for the top
  output int                            errors,
  output int                            pending,
  output int                            checked,
  output int                            pulses
);

  // One date-time as shown on the result port
  typedef struct packed {
    logic [calt_pkg::YEAR_W-1:0]   year;
    logic [calt_pkg::MONTH_W-1:0]  month;
    logic [calt_pkg::DAY_W-1:0]    day;
    logic [calt_pkg::HOUR_W-1:0]   hour;
    logic [calt_pkg::MINUTE_W-1:0] minute;
    logic [calt_pkg::SECOND_W-1:0] second;
    logic                          pulse;
  } stamp_t;

  stamp_t                       now_cal;
  stamp_t                       due_times[$];
  logic [calt_pkg::PRESC_W-1:0] ms_cnt;
  logic [calt_pkg::PRESC_W-1:0] prescale;

  // Days in month m of year y; bad month numbers count as 31 days
  function automatic int unsigned month_length(input logic [calt_pkg::MONTH_W-1:0] m,
                                               input logic [calt_pkg::YEAR_W-1:0] y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      calt_pkg::MON_FEB: return leap ? 29 : 28;
      calt_pkg::MON_APR, calt_pkg::MON_JUN,
      calt_pkg::MON_SEP, calt_pkg::MON_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  // Date-time one second later, carries rippling up to the year
  function automatic stamp_t next_second(input stamp_t t);
    stamp_t n;
    n = t;
    n.pulse = 1'b1;
    if (int'(t.second) + 1 < 60) begin
      n.second = t.second + 6'd1;
      return n;
    end
    n.second = '0;
    if (int'(t.minute) + 1 < 60) begin
      n.minute = t.minute + 6'd1;
      return n;
    end
    n.minute = '0;
    if (int'(t.hour) + 1 < 24) begin
      n.hour = t.hour + 5'd1;
      return n;
    end
    n.hour = '0;
    if (int'(t.day) + 1 <= int'(month_length(t.month, t.year))) begin
      n.day = t.day + 5'd1;
      return n;
    end
    n.day = 5'd1;
    if (int'(t.month) + 1 <= 12) begin
      n.month = t.month + 4'd1;
      return n;
    end
    n.month = 4'd1;
    if (int'(t.year) + 1 <= 9999) n.year = t.year + 14'd1;
    else n.year = '0;
    return n;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side first: a word taken now belongs to an older input word
  always @(posedge clk) begin
    stamp_t want;
    if (rst) begin
      ms_cnt         = '0;
      prescale       = calt_pkg::TPS_RESET;
      now_cal        = '0;
      now_cal.year   = calt_pkg::YEAR_RESET;
      now_cal.month  = calt_pkg::MONTH_RESET;
      now_cal.day    = calt_pkg::DAY_RESET;
      due_times.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_times.size() == 0) begin
          $error("result word with no expectation pending");
          errors++;
        end else begin
          want = due_times.pop_front();
          check_field("cur_year", 32'(want.year), 32'(cur_year));
          check_field("cur_month", 32'(want.month), 32'(cur_month));
          check_field("cur_day", 32'(want.day), 32'(cur_day));
          check_field("cur_hour", 32'(want.hour), 32'(cur_hour));
          check_field("cur_minute", 32'(want.minute), 32'(cur_minute));
          check_field("cur_second", 32'(want.second), 32'(cur_second));
          check_field("second_pulse", 32'(want.pulse), 32'(second_pulse));
          checked++;
        end
      end

      if (cfg_valid && cfg_ready) prescale = cfg_data;

      // Predict the word just accepted
      if (in_valid && in_ready) begin
        if (action == calt_pkg::ACT_LOAD) begin
          now_cal.year   = new_year;
          now_cal.month  = new_month;
          now_cal.day    = new_day;
          now_cal.hour   = new_hour;
          now_cal.minute = new_minute;
          now_cal.second = new_second;
          now_cal.pulse  = 1'b0;
        end else if (int'(ms_cnt) + 1 >= int'(prescale)) begin
          // also covers a zero prescale and one lowered under the count
          ms_cnt  = '0;
          now_cal = next_second(now_cal);
          pulses++;
        end else begin
          ms_cnt        = ms_cnt + 10'd1;
          now_cal.pulse = 1'b0;
        end
        due_times.push_back(now_cal);
      end
    end
    pending = due_times.size();
  end

endmodule

[sim/testbench.sv]
// Top of the calendar time counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 2000;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [calt_pkg::PRESC_W-1:0]  cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          action;
  logic [calt_pkg::YEAR_W-1:0]   new_year;
  logic [calt_pkg::MONTH_W-1:0]  new_month;
  logic [calt_pkg::DAY_W-1:0]    new_day;
  logic [calt_pkg::HOUR_W-1:0]   new_hour;
  logic [calt_pkg::MINUTE_W-1:0] new_minute;
  logic [calt_pkg::SECOND_W-1:0] new_second;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [calt_pkg::YEAR_W-1:0]   cur_year;
  logic [calt_pkg::MONTH_W-1:0]  cur_month;
  logic [calt_pkg::DAY_W-1:0]    cur_day;
  logic [calt_pkg::HOUR_W-1:0]   cur_hour;
  logic [calt_pkg::MINUTE_W-1:0] cur_minute;
  logic [calt_pkg::SECOND_W-1:0] cur_second;
  logic                          second_pulse;

  int fail_count;
  int pending;
  int checked;
  int pulses;
  int words_sent;
  int loads_sent;
  int settings_used;
  int quiet_cycles;
  bit steady;

  calendar_time_counter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .new_year     (new_year),
    .new_month    (new_month),
    .new_day      (new_day),
    .new_hour     (new_hour),
    .new_minute   (new_minute),
    .new_second   (new_second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cur_year     (cur_year),
    .cur_month    (cur_month),
    .cur_day      (cur_day),
    .cur_hour     (cur_hour),
    .cur_minute   (cur_minute),
    .cur_second   (cur_second),
    .second_pulse (second_pulse)
  );

  calt_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .new_year     (new_year),
    .new_month    (new_month),
    .new_day      (new_day),
    .new_hour     (new_hour),
    .new_minute   (new_minute),
    .new_second   (new_second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cur_year     (cur_year),
    .cur_month    (cur_month),
    .cur_day      (cur_day),
    .cur_hour     (cur_hour),
    .cur_minute   (cur_minute),
    .cur_second   (cur_second),
    .second_pulse (second_pulse),
    .errors       (fail_count),
    .pending      (pending),
    .checked      (checked),
    .pulses       (pulses)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result back-pressure, off during steady stretches
  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(99) >= 34);
  end

  // Watchdog: too long without any word moving ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one input word after a random gap and hold it until taken
  task automatic send_word(input logic act, input logic [calt_pkg::YEAR_W-1:0] y,
                           input logic [calt_pkg::MONTH_W-1:0] mo,
                           input logic [calt_pkg::DAY_W-1:0] d,
                           input logic [calt_pkg::HOUR_W-1:0] h,
                           input logic [calt_pkg::MINUTE_W-1:0] mi,
                           input logic [calt_pkg::SECOND_W-1:0] s);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    action     = act;
    new_year   = y;
    new_month  = mo;
    new_day    = d;
    new_hour   = h;
    new_minute = mi;
    new_second = s;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
    if (act == calt_pkg::ACT_LOAD) loads_sent++;
  endtask

  // Tick with junk in the unused load fields
  task automatic tick_word();
    send_word(calt_pkg::ACT_TICK, calt_pkg::YEAR_W'($urandom),
              calt_pkg::MONTH_W'($urandom), calt_pkg::DAY_W'($urandom),
              calt_pkg::HOUR_W'($urandom), calt_pkg::MINUTE_W'($urandom),
              calt_pkg::SECOND_W'($urandom));
  endtask

  // Wait until every result is back, then write the prescale register
  task automatic set_prescale(input logic [calt_pkg::PRESC_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // Load mostly near a rollover; some loads carry raw, out-of-range fields
  task automatic send_random_load();
    logic [calt_pkg::YEAR_W-1:0]   y;
    logic [calt_pkg::MONTH_W-1:0]  mo;
    logic [calt_pkg::DAY_W-1:0]    d;
    logic [calt_pkg::HOUR_W-1:0]   h;
    logic [calt_pkg::MINUTE_W-1:0] mi;
    logic [calt_pkg::SECOND_W-1:0] s;
    if ($urandom_range(99) < 15) begin
      y  = calt_pkg::YEAR_W'($urandom);
      mo = calt_pkg::MONTH_W'($urandom);
      d  = calt_pkg::DAY_W'($urandom);
      h  = calt_pkg::HOUR_W'($urandom);
      mi = calt_pkg::MINUTE_W'($urandom);
      s  = calt_pkg::SECOND_W'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0:       y = calt_pkg::YEAR_LAST;
        1:       y = calt_pkg::YEAR_W'($urandom_range(0, 24) * 400);
        2:       y = calt_pkg::YEAR_W'($urandom_range(0, 99) * 100);
        3:       y = calt_pkg::YEAR_W'($urandom_range(0, 2499) * 4);
        4:       y = calt_pkg::YEAR_W'($urandom_range(9996, 9999));
        default: y = calt_pkg::YEAR_W'($urandom_range(0, 9999));
      endcase
      if ($urandom_range(99) < 40) begin
        mo = $urandom_range(1) ? calt_pkg::MON_FEB : calt_pkg::MON_DEC;
      end else begin
        mo = calt_pkg::MONTH_W'($urandom_range(1, 12));
      end
      d  = ($urandom_range(99) < 60) ? calt_pkg::DAY_W'($urandom_range(28, 31))
                                     : calt_pkg::DAY_W'($urandom_range(1, 31));
      h  = ($urandom_range(99) < 60) ? calt_pkg::HOUR_LAST
                                     : calt_pkg::HOUR_W'($urandom_range(0, 23));
      mi = ($urandom_range(99) < 60) ? calt_pkg::MINUTE_LAST
                                     : calt_pkg::MINUTE_W'($urandom_range(0, 59));
      s  = ($urandom_range(99) < 60) ? calt_pkg::SECOND_W'($urandom_range(50, 59))
                                     : calt_pkg::SECOND_W'($urandom_range(0, 59));
    end
    send_word(calt_pkg::ACT_LOAD, y, mo, d, h, mi, s);
  endtask

  task automatic run_phase(input int words, input int load_pct);
    repeat (words) begin
      if ($urandom_range(99) < load_pct) send_random_load();
      else tick_word();
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    action     = calt_pkg::ACT_TICK;
    new_year   = '0;
    new_month  = '0;
    new_day    = '0;
    new_hour   = '0;
    new_minute = '0;
    new_second = '0;
    steady     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset prescale: a few ticks, no second yet
    send_word(calt_pkg::ACT_TICK, '0, '0, '0, '0, '0, '0);
    send_word(calt_pkg::ACT_TICK, '1, '1, '1, '1, '1, '1);
    tick_word();
    // Prescale lowered under the running count: next tick closes a second
    set_prescale(10'd2);
    tick_word();

    // One tick per second for the calendar corners
    set_prescale(10'd1);
    send_word(calt_pkg::ACT_LOAD, 14'd9999, calt_pkg::MON_DEC, 5'd31, 5'd23, 6'd59, 6'd59);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, 14'd2000, calt_pkg::MON_FEB, 5'd28, 5'd23, 6'd59, 6'd59);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, 14'd2000, calt_pkg::MON_FEB, 5'd29, 5'd23, 6'd59, 6'd59);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, 14'd1900, calt_pkg::MON_FEB, 5'd28, 5'd23, 6'd59, 6'd59);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, 14'd2024, calt_pkg::MON_FEB, 5'd28, 5'd23, 6'd59, 6'd59);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, 14'd2023, calt_pkg::MON_FEB, 5'd28, 5'd23, 6'd59, 6'd59);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, 14'd2001, calt_pkg::MON_APR, 5'd30, 5'd23, 6'd59, 6'd59);
    tick_word();
    // every load field at its top code, then all zero
    send_word(calt_pkg::ACT_LOAD, '1, '1, '1, '1, '1, '1);
    tick_word();
    send_word(calt_pkg::ACT_LOAD, '0, '0, '0, '0, '0, '0);
    tick_word();

    // Zero prescale: every tick closes a second
    set_prescale(10'd0);
    tick_word();
    tick_word();

    // Random phases over several prescale settings
    set_prescale(10'd1);
    run_phase(90, 12);
    set_prescale(10'd2);
    steady = 1'b1;
    run_phase(100, 10);
    steady = 1'b0;
    set_prescale(10'd0);
    run_phase(50, 12);
    set_prescale(10'd300);
    run_phase(330, 1);
    set_prescale(10'd5);
    run_phase(80, 8);
    set_prescale(10'd1);
    run_phase(80, 15);

    // Drain
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d words, %0d of them loads, over %0d prescale settings",
             words_sent, loads_sent, settings_used);
    $display("Checked %0d results, %0d of them closing a second", checked, pulses);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
